// ----- rtl/msd_pkg.sv -----
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants for the maximal square block
// Widths, register indexes and the records that pass between the front end,
// the queue and the back end.
// ----------------------------------------------------------------------------
package msd_pkg;

    // Line buffer depth; the widest map row the block handles.
    localparam int MAX_COLUMNS = 1024;
    localparam int COL_W       = $clog2(MAX_COLUMNS);

    localparam int CHAR_W   = 8;
    localparam int SIZE_W   = 11;
    localparam int ROW_W    = 16;
    localparam int CCOUNT_W = 11;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Decoupling queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_CHAR = 2'd2;

    localparam logic [CHAR_W-1:0]   RESET_OBSTACLE = 8'd111;
    localparam logic [CCOUNT_W-1:0] RESET_COLUMNS  = 11'd1;
    localparam logic [ROW_W-1:0]    RESET_ROWS     = 16'd1;

    typedef struct packed {
        logic [CCOUNT_W-1:0] column_count;
        logic [ROW_W-1:0]    row_count;
        logic [CHAR_W-1:0]   obstacle_char;
    } t_cfg;

    // One classified cell as it travels from the front end to the back end.
    typedef struct packed {
        logic             obstacle;  // cell is blocked
        logic             edge_cell; // last row or last column of the map
        logic             last;      // final cell of the stream, the map's first cell
        logic [COL_W-1:0] col;       // position counted from the row's right end
    } t_cell;

endpackage

// ----- rtl/maximal_square_dp.sv -----
// ----------------------------------------------------------------------------
// maximal_square_dp: streaming largest free square per map cell
// Takes map characters in reverse scan order and returns, for each cell, the
// side of the largest obstacle-free square with that cell at its top-left.
// ----------------------------------------------------------------------------
// Usage:
// Map characters arrive one per beat on the input channel (i_in_valid,
// o_in_ready, i_cell_char), last row first and each row from its last column
// to its first. Every input beat yields exactly one output beat (o_out_valid,
// i_out_ready, o_square_size, o_last_cell), in order; o_last_cell marks the
// map's first cell, which closes the map, and the next beat starts a new map.
// Throughput is one cell per clock cycle while the receiver keeps up: the
// line buffer RAM is read for one cell and written for the previous one in
// the same cycle. A result passes the queue, compute stage and output register.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index,
// i_cfg_data) is always ready; write it only while no result is outstanding.
// After reset the block zeroes all 1024 line buffer entries, one entry per
// cycle, with o_in_ready low; configuration writes are taken meanwhile.
// When the receiver stalls, the held result stays put while a four-entry
// queue keeps taking input; o_in_ready falls only once that queue is full.
// ----------------------------------------------------------------------------
module maximal_square_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [msd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [msd_pkg::CFG_W-1:0]      i_cfg_data,
    // Input cell channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [msd_pkg::CHAR_W-1:0]     i_cell_char,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [msd_pkg::SIZE_W-1:0]     o_square_size,
    output logic                           o_last_cell
);

    // Configuration registers. Writes to an index past the list are dropped.
    msd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.column_count  <= msd_pkg::RESET_COLUMNS;
            r_cfg.row_count     <= msd_pkg::RESET_ROWS;
            r_cfg.obstacle_char <= msd_pkg::RESET_OBSTACLE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                msd_pkg::REG_COLUMN_COUNT: begin
                    r_cfg.column_count <= i_cfg_data[msd_pkg::CCOUNT_W-1:0];
                end
                msd_pkg::REG_ROW_COUNT: begin
                    r_cfg.row_count <= i_cfg_data[msd_pkg::ROW_W-1:0];
                end
                msd_pkg::REG_OBSTACLE_CHAR: begin
                    r_cfg.obstacle_char <= i_cfg_data[msd_pkg::CHAR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Front end to queue to back end.
    logic           push;
    logic           pop;
    logic           q_valid;
    logic           q_full;
    logic           clearing;
    msd_pkg::t_cell front_cell;
    msd_pkg::t_cell q_cell;

    msd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .i_cell_char  (i_cell_char),
        .i_queue_full (q_full),
        .i_clearing   (clearing),
        .o_in_ready   (o_in_ready),
        .o_push       (push),
        .o_cell       (front_cell)
    );

    msd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cell),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_cell)
    );

    msd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cell      (q_cell),
        .o_q_pop       (pop),
        .o_clearing    (clearing),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_square_size (o_square_size),
        .o_last_cell   (o_last_cell)
    );

endmodule

// ----- rtl/msd_ram.sv -----
// ----------------------------------------------------------------------------
// msd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module msd_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/msd_queue.sv -----
// ----------------------------------------------------------------------------
// msd_queue: short FIFO of classified cells
// Lets the front end keep accepting while the back end waits on the output.
// ----------------------------------------------------------------------------
module msd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  msd_pkg::t_cell       i_data,
    input  logic                 i_pop,
    output logic                 o_valid,
    output logic                 o_full,
    output msd_pkg::t_cell       o_data
);

    msd_pkg::t_cell r_mem [msd_pkg::QUEUE_DEPTH];
    logic [msd_pkg::QPTR_W-1:0] r_wptr;
    logic [msd_pkg::QPTR_W-1:0] r_rptr;
    logic [msd_pkg::QPTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (msd_pkg::QPTR_W + 1)'(msd_pkg::QUEUE_DEPTH));
    assign o_data  = r_mem[r_rptr];

endmodule

// ----- rtl/msd_front.sv -----
// ----------------------------------------------------------------------------
// msd_front: input acceptance and cell classification
// Tracks the column and row position of the stream and tags each cell as
// obstacle, map edge and end of map before it goes into the queue.
// ----------------------------------------------------------------------------
module msd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  msd_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    input  logic [msd_pkg::CHAR_W-1:0]  i_cell_char,
    input  logic                        i_queue_full,
    input  logic                        i_clearing,
    output logic                        o_in_ready,
    output logic                        o_push,
    output msd_pkg::t_cell              o_cell
);

    logic [msd_pkg::COL_W-1:0] r_col;
    logic [msd_pkg::ROW_W-1:0] r_row;
    logic [msd_pkg::COL_W-1:0] n_col;
    logic [msd_pkg::ROW_W-1:0] n_row;
    logic [msd_pkg::COL_W-1:0] last_col;
    logic [msd_pkg::ROW_W-1:0] last_row;
    logic [31:0]               cc_ext;
    logic                      row_end;
    logic                      map_end;

    // Effective last column: a zero count means one column, and the count
    // is clipped to the line buffer depth.
    always_comb begin
        cc_ext = 32'(i_cfg.column_count);
        if (cc_ext == 32'd0) begin
            last_col = '0;
        end else if (cc_ext > 32'(msd_pkg::MAX_COLUMNS)) begin
            last_col = msd_pkg::COL_W'(msd_pkg::MAX_COLUMNS - 1);
        end else begin
            last_col = msd_pkg::COL_W'(cc_ext - 32'd1);
        end
        last_row = (i_cfg.row_count == '0) ? '0 : i_cfg.row_count - 1'b1;
    end

    assign row_end = (r_col >= last_col);
    assign map_end = row_end && (r_row >= last_row);

    assign o_in_ready = !i_queue_full && !i_clearing;
    assign o_push     = i_in_valid && o_in_ready;

    assign o_cell.obstacle  = (i_cell_char == i_cfg.obstacle_char);
    assign o_cell.edge_cell = (r_row == '0) || (r_col == '0);
    assign o_cell.last      = map_end;
    assign o_cell.col       = r_col;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (row_end) begin
                n_col = '0;
                n_row = map_end ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ----- rtl/msd_back.sv -----
// ----------------------------------------------------------------------------
// msd_back: line buffer, min-plus-one update and output register
// Reads the row-below value for each queued cell, forms the square size and
// writes it back to the line buffer. Also runs the clearing pass after reset.
// ----------------------------------------------------------------------------
module msd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  msd_pkg::t_cell              i_q_cell,
    output logic                        o_q_pop,
    output logic                        o_clearing,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [msd_pkg::SIZE_W-1:0]  o_square_size,
    output logic                        o_last_cell
);

    // Clearing pass state.
    logic                       r_clr_busy;
    logic [msd_pkg::COL_W-1:0]  r_clr_addr;

    // Compute stage.
    logic                       r_b_valid;
    msd_pkg::t_cell             r_b_cell;
    logic                       r_fwd;
    logic [msd_pkg::SIZE_W-1:0] r_fwd_data;

    // Neighbor registers.
    logic [msd_pkg::SIZE_W-1:0] r_right;
    logic [msd_pkg::SIZE_W-1:0] r_below_right;

    // Output register.
    logic                       r_out_valid;
    logic [msd_pkg::SIZE_W-1:0] r_out_size;
    logic                       r_out_last;

    logic                       b_fire;
    logic                       pop;
    logic [msd_pkg::SIZE_W-1:0] ram_q;
    logic [msd_pkg::SIZE_W-1:0] down;
    logic [msd_pkg::SIZE_W-1:0] min_a;
    logic [msd_pkg::SIZE_W-1:0] min_b;
    logic [msd_pkg::SIZE_W:0]   inc;
    logic [msd_pkg::SIZE_W-1:0] v;
    logic                       ram_we;
    logic [msd_pkg::COL_W-1:0]  ram_waddr;
    logic [msd_pkg::SIZE_W-1:0] ram_wdata;

    assign b_fire = r_b_valid && (!r_out_valid || i_out_ready);
    assign pop    = i_q_valid && !r_clr_busy && (!r_b_valid || b_fire);

    // A read that coincides with the write of the same entry sees old data,
    // so the written value is carried alongside.
    assign down = r_fwd ? r_fwd_data : ram_q;

    always_comb begin
        min_a = (down < r_below_right) ? down : r_below_right;
        min_b = (min_a < r_right) ? min_a : r_right;
        inc   = {1'b0, min_b} + 1'b1;
        if (r_b_cell.obstacle) begin
            v = '0;
        end else if (r_b_cell.edge_cell) begin
            v = msd_pkg::SIZE_W'(1);
        end else if (inc[msd_pkg::SIZE_W]) begin
            v = msd_pkg::SIZE_MAX;
        end else begin
            v = inc[msd_pkg::SIZE_W-1:0];
        end
    end

    assign ram_we    = r_clr_busy || b_fire;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_b_cell.col;
    assign ram_wdata = r_clr_busy ? '0 : v;

    msd_ram #(
        .WIDTH (msd_pkg::SIZE_W),
        .DEPTH (msd_pkg::MAX_COLUMNS)
    ) u_below_row (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (pop),
        .i_raddr (i_q_cell.col),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == msd_pkg::COL_W'(msd_pkg::MAX_COLUMNS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_right       <= '0;
            r_below_right <= '0;
        end else begin
            if (pop) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                r_out_valid   <= 1'b1;
                r_right       <= v;
                r_below_right <= down;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b_cell   <= i_q_cell;
            r_fwd      <= b_fire && (i_q_cell.col == r_b_cell.col);
            r_fwd_data <= v;
        end
        if (b_fire) begin
            r_out_size <= v;
            r_out_last <= r_b_cell.last;
        end
    end

    assign o_q_pop       = pop;
    assign o_clearing    = r_clr_busy;
    assign o_out_valid   = r_out_valid;
    assign o_square_size = r_out_size;
    assign o_last_cell   = r_out_last;

    // Blocked cells always yield a zero square.
    a_obstacle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire && r_b_cell.obstacle |=> r_out_valid && (r_out_size == '0))
        else $error("obstacle cell produced a nonzero square size");

    // Free cells always yield at least a one-cell square.
    a_free_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire && !r_b_cell.obstacle |=> r_out_size != '0)
        else $error("free cell produced a zero square size");

    // Nothing leaves the queue while the line buffer is being cleared.
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !pop)
        else $error("queue popped during the clearing pass");

    // A result waiting on a stalled receiver is not overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_size))
        else $error("stalled result changed");

endmodule
